// ===== src/ssd_pkg.sv =====
// Shared constants and types for the SSD stereo disparity block.
package ssd_pkg;
	localparam int MaxWidth = 1024;
	localparam int MaxHalf = 7;
	localparam int MaxDisp = 64;
	localparam int StoreLines = 2 * MaxHalf + 1;
	localparam int ColW = $clog2(MaxWidth);
	localparam int LineW = $clog2(StoreLines);
	localparam int AddrW = $clog2(StoreLines * MaxWidth);
	localparam int ShiftW = $clog2(MaxDisp + 1);
	localparam int HalfW = $clog2(MaxHalf + 1);
	localparam int CostW = 24;
	localparam int RowW = 12;

	localparam logic [1:0] RegDisp = 2'd0;
	localparam logic [1:0] RegHalf = 2'd1;
	localparam logic [1:0] RegWidth = 2'd2;
	localparam logic [1:0] RegHeight = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic store;      // write the accepted pixel pair
		logic clr_sum;    // start a new shift
		logic rd;         // issue a window read
		logic acc;        // accumulate the read data of the previous read
		logic judge;      // compare the finished sum with the best so far
		logic load_out;   // held low by the controller and not used by the datapath
	} ssd_cmd_t;
endpackage

// ===== src/ssd_datapath.sv =====
// Line stores, squared difference accumulator and best-shift tracking.
module ssd_datapath import ssd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ssd_cmd_t              cmd,
	input  logic [AddrW-1:0]      wr_addr,
	input  logic [7:0]            left_in,
	input  logic [7:0]            right_in,
	input  logic [AddrW-1:0]      rd_addr_l,
	input  logic [AddrW-1:0]      rd_addr_r,
	input  logic [ShiftW-1:0]     cur_shift,
	input  logic                  first_shift,
	output logic [ShiftW-2:0]     best_shift,
	output logic [CostW-1:0]      best_cost
);
	logic [7:0] left_mem [StoreLines*MaxWidth];
	logic [7:0] right_mem [StoreLines*MaxWidth];
	logic [7:0] l_s1, r_s1;
	logic [CostW-1:0] sum_q;
	logic signed [8:0] diff;
	logic [15:0] sq;

	always_ff @(posedge clk) begin
		if (cmd.store) left_mem[wr_addr] <= left_in;
		l_s1 <= left_mem[rd_addr_l];
	end
	always_ff @(posedge clk) begin
		if (cmd.store) right_mem[wr_addr] <= right_in;
		r_s1 <= right_mem[rd_addr_r];
	end

	assign diff = $signed({1'b0, l_s1}) - $signed({1'b0, r_s1});
	assign sq = 16'(diff * diff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			best_cost <= '0;
			best_shift <= '0;
		end else begin
			if (cmd.clr_sum) sum_q <= '0;
			else if (cmd.acc) sum_q <= sum_q + CostW'(sq);
			if (cmd.judge && (first_shift || sum_q < best_cost)) begin
				best_cost <= sum_q;
				best_shift <= cur_shift[ShiftW-2:0];
			end
		end
	end
endmodule

// ===== src/ssd_ctrl.sv =====
// Controller: pixel counters, window address sequencing and handshakes.
module ssd_ctrl import ssd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [11:0]        cfg_data,
	output ssd_cmd_t           cmd,
	output logic [AddrW-1:0]   wr_addr,
	output logic [AddrW-1:0]   rd_addr_l,
	output logic [AddrW-1:0]   rd_addr_r,
	output logic [ShiftW-1:0]  cur_shift,
	output logic               first_shift,
	output logic [RowW-1:0]    center_row,
	output logic [ColW-1:0]    center_col
);
	typedef enum logic [2:0] {IDLE, READ, DRAIN, JUDGE, DONE} state_t;
	state_t state_q;

	logic [6:0]  disp_q;
	logic [2:0]  half_q;
	logic [10:0] width_q;
	logic [11:0] height_q;
	logic [RowW-1:0] row_q;
	logic [ColW-1:0] col_q, c_q;
	logic [LineW-1:0] line_q, wline_q, rline_q;
	logic [HalfW:0] i_q, j_q;
	logic [ShiftW-1:0] shift_q;
	logic [1:0] drain_q;

	logic [10:0] w_eff;
	logic [11:0] h_eff;
	logic [HalfW-1:0] h_e;
	logic [ShiftW-1:0] nd;
	logic [HalfW:0] span;
	logic [RowW-1:0] r_c;
	logic [ColW-1:0] c_c;
	logic in_acc, has_out, last_col;
	logic [ColW:0] lc;

	assign w_eff = (width_q == 0) ? 11'd1 : (width_q > 11'(MaxWidth)) ? 11'(MaxWidth) : width_q;
	assign h_eff = (height_q == 0) ? 12'd1 : height_q;
	assign h_e = (half_q > 3'(MaxHalf)) ? HalfW'(MaxHalf) : HalfW'(half_q);
	assign nd = (disp_q == 0) ? ShiftW'(1) : (disp_q > 7'(MaxDisp)) ? ShiftW'(MaxDisp)
		: ShiftW'(disp_q);
	assign span = {h_e, 1'b0};
	assign r_c = (row_q >= h_eff) ? RowW'(h_eff - 12'd1) : row_q;
	assign c_c = (11'(col_q) >= w_eff) ? ColW'(w_eff - 11'd1) : col_q;
	assign in_acc = in_valid && in_ready;
	assign has_out = (r_c >= RowW'(span)) && (c_c >= ColW'(span));
	assign last_col = (11'(c_c) + 11'd1 >= w_eff);

	// A pending configuration word takes priority over pixel words.
	assign in_ready = (state_q == IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == IDLE);
	assign out_valid = (state_q == DONE);
	assign cur_shift = shift_q;
	assign first_shift = (shift_q == 0);
	assign wr_addr = AddrW'(line_q) * AddrW'(MaxWidth) + AddrW'(c_c);
	assign lc = (ColW+1)'(c_q) - (ColW+1)'(span) + (ColW+1)'(j_q);
	assign rd_addr_l = AddrW'(rline_q) * AddrW'(MaxWidth) + AddrW'(lc);
	assign rd_addr_r = AddrW'(rline_q) * AddrW'(MaxWidth) + AddrW'(lc - (ColW+1)'(shift_q));

	always_comb begin
		cmd = '0;
		cmd.store = in_acc;
		cmd.clr_sum = in_acc || (state_q == JUDGE);
		cmd.rd = (state_q == READ);
		cmd.acc = drain_q[0];
		cmd.judge = (state_q == JUDGE);
		cmd.load_out = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			disp_q <= 7'd64; half_q <= 3'd3; width_q <= 11'd640; height_q <= 12'd480;
			row_q <= '0; col_q <= '0; line_q <= '0;
			drain_q <= '0; i_q <= '0; j_q <= '0; shift_q <= '0;
			c_q <= '0; wline_q <= '0; rline_q <= '0;
			center_row <= '0; center_col <= '0;
		end else begin
			drain_q <= {drain_q[0], state_q == READ};
			case (state_q)
				IDLE: begin
					if (cfg_valid) begin
						case (cfg_index)
							RegDisp: disp_q <= cfg_data[6:0];
							RegHalf: half_q <= cfg_data[2:0];
							RegWidth: width_q <= cfg_data[10:0];
							RegHeight: height_q <= cfg_data;
							default: ;
						endcase
						row_q <= '0; col_q <= '0; line_q <= '0;
					end else if (in_valid) begin
						c_q <= c_c;
						// Oldest window line sits span lines back in the ring.
						wline_q <= (line_q >= LineW'(span)) ? line_q - LineW'(span)
							: LineW'(line_q + LineW'(StoreLines) - LineW'(span));
						rline_q <= (line_q >= LineW'(span)) ? line_q - LineW'(span)
							: LineW'(line_q + LineW'(StoreLines) - LineW'(span));
						i_q <= '0; j_q <= '0; shift_q <= '0;
						center_row <= r_c - RowW'(h_e);
						center_col <= c_c - ColW'(h_e);
						if (last_col) begin
							col_q <= '0;
							if (12'(r_c) + 12'd1 >= h_eff) begin
								row_q <= '0; line_q <= '0;
							end else begin
								row_q <= r_c + 1'b1;
								line_q <= (line_q == LineW'(StoreLines - 1)) ? '0 : line_q + 1'b1;
							end
						end else begin
							col_q <= c_c + 1'b1;
							row_q <= r_c;
						end
						if (has_out) state_q <= READ;
					end
				end
				READ: begin
					if (j_q == span) begin
						j_q <= '0;
						rline_q <= (rline_q == LineW'(StoreLines - 1)) ? '0 : rline_q + 1'b1;
						if (i_q == span) begin
							i_q <= '0;
							state_q <= DRAIN;
						end else i_q <= i_q + 1'b1;
					end else j_q <= j_q + 1'b1;
				end
				DRAIN: if (!drain_q[0] && !drain_q[1]) state_q <= JUDGE;
				JUDGE: begin
					rline_q <= wline_q;
					if (shift_q + 1'b1 < nd &&
						ColW'(shift_q + 1'b1) <= center_col - ColW'(h_e)) begin
						shift_q <= shift_q + 1'b1;
						state_q <= READ;
					end else state_q <= DONE;
				end
				DONE: if (out_ready) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

// ===== src/ssd_stereo_disparity_left_ref.sv =====
// Top level of the SSD block-matching stereo disparity unit.
//
// Pixel pairs enter on in_valid/in_ready in raster order, one word per pair.
// Each word is written to the left and right line stores, which keep the last
// 2*MaxHalf+1 lines. When a word completes a full window around an interior centre,
// a sequencer reads the window once per shift, one pixel pair per cycle from
// one read port of each store, and accumulates squared differences.
// While it computes a result the block holds in_ready low, so it takes no new
// pixel pair until that result has been handed over.
// The result word (disparity, min_cost, center_row, center_col) is held on
// out_valid until out_ready; no new pixel is taken while it waits.
// Configuration words are taken only while idle and restart the frame.
// Reset returns the registers to 64 shifts, h = 3, 640 x 480 and clears
// the pixel counters; line stores are not cleared.
module ssd_stereo_disparity_left_ref import ssd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  left_pixel,
	input  logic [7:0]  right_pixel,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  disparity,
	output logic [23:0] min_cost,
	output logic [11:0] center_row,
	output logic [9:0]  center_col,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);
	ssd_cmd_t cmd;
	logic [AddrW-1:0] wr_addr, rd_l, rd_r;
	logic [ShiftW-1:0] cur_shift;
	logic first_shift;

	ssd_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .cmd, .wr_addr,
		.rd_addr_l(rd_l), .rd_addr_r(rd_r), .cur_shift, .first_shift,
		.center_row, .center_col
	);

	ssd_datapath u_dp (
		.clk, .arst_n, .cmd, .wr_addr, .left_in(left_pixel), .right_in(right_pixel),
		.rd_addr_l(rd_l), .rd_addr_r(rd_r), .cur_shift, .first_shift,
		.best_shift(disparity), .best_cost(min_cost)
	);
endmodule

// ===== src/ssd_checker.sv =====
// Port-level checks for the stereo disparity block, bound to the top level.
module ssd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic cfg_ready,
	input logic [23:0] min_cost
);
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> cfg_ready) else $error("input ready outside idle");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(min_cost))
		else $error("result dropped");
	a_cost_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> min_cost <= 24'd14630625) else $error("cost out of range");
endmodule

bind ssd_stereo_disparity_left_ref ssd_checker u_chk (.*);

// ===== verif/tb.sv =====
// Self-checking testbench for the SSD stereo disparity unit, left image as reference.
`timescale 1ns / 100ps

module tb import ssd_pkg::*;;

	typedef struct packed {
		logic [5:0]  disp;
		logic [23:0] cost;
		logic [11:0] row;
		logic [9:0]  col;
	} disparity_word_t;

	typedef struct packed {
		logic [7:0] lpix;
		logic [7:0] rpix;
	} pixel_pair_t;

	localparam int ModeRandom = 0;
	localparam int ModeTexture = 1;
	localparam int ModeMaxCost = 2;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  left_pixel;
	logic [7:0]  right_pixel;
	logic        out_valid;
	logic        out_ready;
	logic [5:0]  disparity;
	logic [23:0] min_cost;
	logic [11:0] center_row;
	logic [9:0]  center_col;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [11:0] cfg_data;

	pixel_pair_t     pixel_q[$];
	disparity_word_t disparity_q[$];
	bit              failed;
	bit              calm;

	// Own copy of the block's registers, counters and line stores.
	bit [6:0]  shifts_reg;
	bit [2:0]  half_reg;
	bit [10:0] width_reg;
	bit [11:0] height_reg;
	int        row_pos;
	int        col_pos;
	bit [7:0]  left_lines[StoreLines * MaxWidth];
	bit [7:0]  right_lines[StoreLines * MaxWidth];

	ssd_stereo_disparity_left_ref dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int eff_width();
		return width_reg == 0 ? 1 : (width_reg > MaxWidth ? MaxWidth : int'(width_reg));
	endfunction

	function automatic int eff_height();
		return height_reg == 0 ? 1 : int'(height_reg);
	endfunction

	task automatic match_window(input bit [7:0] lp, input bit [7:0] rp);
		int w, hg, h, nd, r, c, span, cc, s, i, j, base, lc, d, sum, best, best_s;
		disparity_word_t res;
		w = eff_width();
		hg = eff_height();
		h = half_reg;
		nd = shifts_reg == 0 ? 1 : (shifts_reg > MaxDisp ? MaxDisp : int'(shifts_reg));
		r = row_pos >= hg ? hg - 1 : row_pos;
		c = col_pos >= w ? w - 1 : col_pos;
		span = 2 * h;
		left_lines[(r % StoreLines) * MaxWidth + c] = lp;
		right_lines[(r % StoreLines) * MaxWidth + c] = rp;
		if (r >= span && c >= span) begin
			cc = c - h;
			best = 0;
			best_s = 0;
			for (s = 0; s < nd; s++) begin
				if (s > cc - h)
					break;
				sum = 0;
				for (i = 0; i <= span; i++) begin
					base = ((r - span + i) % StoreLines) * MaxWidth;
					for (j = 0; j <= span; j++) begin
						lc = c - span + j;
						d = int'(left_lines[base + lc]) - int'(right_lines[base + lc - s]);
						sum += d * d;
					end
				end
				if (s == 0 || sum < best) begin
					best = sum;
					best_s = s;
				end
			end
			res.disp = best_s[5:0];
			res.cost = best[23:0];
			res.row = 12'(r - h);
			res.col = 10'(cc);
			disparity_q.push_back(res);
		end
		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = (r + 1 >= hg) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
	endtask

	// Pixel driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			left_pixel <= '0;
			right_pixel <= '0;
		end else begin
			if (in_valid && in_ready)
				match_window(left_pixel, right_pixel);
			if (!in_valid || in_ready) begin
				if (pixel_q.size() > 0 && (calm || $urandom_range(99) >= 8)) begin
					pixel_pair_t p;
					p = pixel_q.pop_front();
					left_pixel <= p.lpix;
					right_pixel <= p.rpix;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || $urandom_range(99) >= 8;
			if (out_valid && out_ready) begin
				if (disparity_q.size() == 0) begin
					$display("%0t: unexpected word: disparity %0d cost %0d row %0d col %0d",
						$time, disparity, min_cost, center_row, center_col);
					failed = 1'b1;
				end else begin
					disparity_word_t e;
					e = disparity_q.pop_front();
					if (e.disp !== disparity) begin
						$display("%0t: disparity expected %0d actual %0d", $time, e.disp, disparity);
						failed = 1'b1;
					end
					if (e.cost !== min_cost) begin
						$display("%0t: min_cost expected %0d actual %0d", $time, e.cost, min_cost);
						failed = 1'b1;
					end
					if (e.row !== center_row) begin
						$display("%0t: center_row expected %0d actual %0d", $time, e.row, center_row);
						failed = 1'b1;
					end
					if (e.col !== center_col) begin
						$display("%0t: center_col expected %0d actual %0d", $time, e.col, center_col);
						failed = 1'b1;
					end
				end
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [11:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			RegDisp:   shifts_reg = data[6:0];
			RegHalf:   half_reg = data[2:0];
			RegWidth:  width_reg = data[10:0];
			RegHeight: height_reg = data[11:0];
			default: ;
		endcase
		row_pos = 0;
		col_pos = 0;
		// A wait for a clock edge with cfg_valid low keeps the next write off this time step.
		@(posedge clk);
	endtask

	task automatic wait_idle();
		while (pixel_q.size() > 0 || in_valid || disparity_q.size() > 0)
			@(posedge clk);
		// A word that yields no result may still be in flight.
		repeat (20) @(posedge clk);
	endtask

	// Writes all registers, then queues n words of the given kind and drains them.
	task automatic run_phase(input int nd, input int h, input int w, input int ht,
			input int n, input int mode);
		int k, r, c, shift, seed, wd, hd;
		pixel_pair_t p;
		write_reg(RegDisp, 12'(nd));
		write_reg(RegHalf, 12'(h));
		write_reg(RegWidth, 12'(w));
		write_reg(RegHeight, 12'(ht));
		wd = eff_width();
		hd = eff_height();
		shift = $urandom_range(nd > 1 ? (nd > 64 ? 63 : nd - 1) : 0);
		seed = $urandom;
		for (k = 0; k < n; k++) begin
			r = (k / wd) % hd;
			c = k % wd;
			if (mode == ModeMaxCost) begin
				p.lpix = 8'd255;
				p.rpix = 8'd0;
			end else if (mode == ModeTexture) begin
				// Right line is the left line moved by a fixed shift, with a little noise.
				p.lpix = 8'((r * 2654435 + c * 40503 + seed) >> 7);
				p.rpix = 8'((r * 2654435 + (c + shift) * 40503 + seed) >> 7);
				if ($urandom_range(9) == 0)
					p.rpix = 8'($urandom);
			end else begin
				p.lpix = 8'($urandom);
				p.rpix = 8'($urandom);
			end
			pixel_q.push_back(p);
		end
		wait_idle();
	endtask

	initial begin
		int total, n, h, w, ht, nd, ph;
		pixel_pair_t p;
		failed = 1'b0;
		calm = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		shifts_reg = 7'd64;
		half_reg = 3'd3;
		width_reg = 11'd640;
		height_reg = 12'd480;
		row_pos = 0;
		col_pos = 0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: pixel extremes with a one-pixel window so every word yields a result.
		write_reg(RegDisp, 12'd3);
		write_reg(RegHalf, 12'd0);
		write_reg(RegWidth, 12'd4);
		write_reg(RegHeight, 12'd2);
		p = '{8'd0, 8'd255}; pixel_q.push_back(p);
		p = '{8'd255, 8'd0}; pixel_q.push_back(p);
		p = '{8'd255, 8'd255}; pixel_q.push_back(p);
		p = '{8'd0, 8'd0}; pixel_q.push_back(p);
		p = '{8'd170, 8'd85}; pixel_q.push_back(p);
		p = '{8'd85, 8'd170}; pixel_q.push_back(p);
		p = '{8'd255, 8'd170}; pixel_q.push_back(p);
		p = '{8'd85, 8'd85}; pixel_q.push_back(p);
		p = '{8'd1, 8'd254}; pixel_q.push_back(p);
		wait_idle();
		// Zero shift count, zero width and zero height; a 1x1 frame with h = 1 is all border.
		run_phase(0, 1, 0, 0, 5, ModeRandom);
		// Smallest frame with h = 0: one result per word, wrapping each word.
		run_phase(1, 0, 1, 1, 6, ModeRandom);
		// Oversized shift count and width saturate; height at its top value.
		run_phase(127, 0, 2047, 4095, 80, ModeTexture);
		// Largest window over a frame that just fits it, with the largest cost.
		run_phase(64, 7, 15, 15, 225, ModeMaxCost);
		run_phase(64, 7, 16, 17, 272, ModeRandom);
		total = 597;

		ph = 0;
		while (total < 1900) begin
			h = $urandom_range(3) == 0 ? 0 : $urandom_range(1, 2);
			nd = $urandom_range(4) == 0 ? 64 : $urandom_range(1, 12);
			w = $urandom_range(2 * h + 1, 24);
			ht = $urandom_range(2 * h + 1, 10);
			n = w * ht * $urandom_range(1, 2) + $urandom_range(w);
			if (n > 300)
				n = 300;
			calm = (ph == 3);
			run_phase(nd, h, w, ht, n, $urandom_range(3) == 0 ? ModeRandom : ModeTexture);
			total += n;
			ph++;
		end
		calm = 1'b0;

		wait_idle();
		repeat (50) @(posedge clk);
		if (!failed)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#50ms;
		$display("Verification failed");
		$finish;
	end
endmodule
